// ----- sv/servo_sweep_pwm_stepper_macros.svh -----
// ----------------------------------------------------------------------------
// Servo sweep stepper assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SERVO_SWEEP_PWM_STEPPER_MACROS_SVH
`define SERVO_SWEEP_PWM_STEPPER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSPWM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSPWM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/sspwm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo sweep stepper package
// Shared types, codes and constants of the servo ramp and duty generator.
// ----------------------------------------------------------------------------
package sspwm_pkg;

  localparam int unsigned DUTY_BITS_DEF = 16;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned PERIOD_W      = 20;

  localparam logic [7:0]  ANGLE_MAX    = 8'd180;
  localparam logic [15:0] MIN_INTERVAL = 16'd10;
  localparam int unsigned US_PER_S     = 1000000;

  // Division by 180 is a shift right by two and a multiply by the rounded-up
  // reciprocal of 45, exact for every product of an angle and a 16-bit span.
  localparam logic [22:0] ANGLE_RECIP    = 23'd5965233;
  localparam int unsigned ANGLE_RECIP_SH = 28;

  localparam logic [15:0] RST_MIN_PULSE = 16'd500;
  localparam logic [15:0] RST_MAX_PULSE = 16'd2400;
  localparam logic [9:0]  RST_PWM_FREQ  = 10'd50;

  typedef enum logic [1:0] {
    KIND_MOVE_LAST = 2'd0,
    KIND_MOVE_FROM = 2'd1,
    KIND_WRITE     = 2'd2,
    KIND_TICK      = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_PULSE = 2'd0,
    CFG_MAX_PULSE = 2'd1,
    CFG_PWM_FREQ  = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    OP_PERIOD,
    OP_DUTY,
    OP_COUNT,
    OP_INTERVAL
  } div_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PERIOD,
    ST_START_DUTY,
    ST_DUTY,
    ST_EMIT,
    ST_COUNT,
    ST_START_IVL,
    ST_INTERVAL
  } state_t;

  typedef struct packed {
    logic    load_in;
    logic    abort;
    logic    set_direct;
    logic    tick_count;
    logic    tick_step;
    logic    set_step;
    logic    div_start;
    div_op_t div_op;
    logic    div_cap;
    div_op_t cap_op;
    logic    commit;
    logic    emit;
  } ctrl_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  ramp_active;
    logic  cd_gt1;
    logic  same_angle;
    logic  short_move;
    logic  div_busy;
    logic  div_done;
    logic  out_free;
  } dp_status_t;

endpackage

// ----- sv/sspwm_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo sweep stepper channels
// Request and result channels with valid and ready handshake.
// ----------------------------------------------------------------------------
interface sspwm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  start_angle;
  logic [7:0]  target_angle;
  logic [15:0] move_ms;
  logic [7:0]  step_degrees;

  modport source (
    output valid, kind, start_angle, target_angle, move_ms, step_degrees,
    input  ready
  );
  modport sink (
    input  valid, kind, start_angle, target_angle, move_ms, step_degrees,
    output ready
  );
endinterface

interface sspwm_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] duty;
  logic [15:0] pulse_us;
  logic [7:0]  angle_out;
  logic        moving;
  logic        move_done;

  modport source (
    output valid, duty, pulse_us, angle_out, moving, move_done,
    input  ready
  );
  modport sink (
    input  valid, duty, pulse_us, angle_out, moving, move_done,
    output ready
  );
endinterface

// ----- sv/sspwm_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo sweep stepper divider
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sspwm_div #(
  parameter int unsigned W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int unsigned CW = $clog2(W);

  logic [W-1:0]  rem_r;
  logic [W-1:0]  quo_r;
  logic [W-1:0]  dsr_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          ge;

  assign trial = {rem_r, quo_r[W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign ge    = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[W-1:0] : trial[W-1:0];
      quo_r <= {quo_r[W-2:0], ge};
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- sv/sspwm_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo sweep stepper controller
// Sequences request decode, the shared divider and the result hand-off.
// ----------------------------------------------------------------------------
`include "servo_sweep_pwm_stepper_macros.svh"

module sspwm_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  sspwm_pkg::dp_status_t  sts,
  output sspwm_pkg::ctrl_cmd_t   cmd
);

  sspwm_pkg::state_t state_r;
  sspwm_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sspwm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      sspwm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = sspwm_pkg::ST_DECODE;
        end
      end
      sspwm_pkg::ST_DECODE: begin
        case (sts.kind)
          sspwm_pkg::KIND_WRITE: begin
            cmd.abort      = 1'b1;
            cmd.set_direct = 1'b1;
            cmd.div_start  = 1'b1;
            cmd.div_op     = sspwm_pkg::OP_PERIOD;
            state_nxt      = sspwm_pkg::ST_PERIOD;
          end
          sspwm_pkg::KIND_TICK: begin
            if (!sts.ramp_active) begin
              state_nxt = sspwm_pkg::ST_IDLE;
            end else if (sts.cd_gt1) begin
              cmd.tick_count = 1'b1;
              state_nxt      = sspwm_pkg::ST_IDLE;
            end else begin
              cmd.tick_step = 1'b1;
              cmd.div_start = 1'b1;
              cmd.div_op    = sspwm_pkg::OP_PERIOD;
              state_nxt     = sspwm_pkg::ST_PERIOD;
            end
          end
          default: begin
            cmd.abort = 1'b1;
            if (sts.same_angle) begin
              state_nxt = sspwm_pkg::ST_IDLE;
            end else begin
              cmd.set_step = 1'b1;
              if (sts.short_move) begin
                state_nxt = sspwm_pkg::ST_IDLE;
              end else begin
                cmd.div_start = 1'b1;
                cmd.div_op    = sspwm_pkg::OP_COUNT;
                state_nxt     = sspwm_pkg::ST_COUNT;
              end
            end
          end
        endcase
      end
      sspwm_pkg::ST_PERIOD: begin
        if (sts.div_done) begin
          cmd.div_cap = 1'b1;
          cmd.cap_op  = sspwm_pkg::OP_PERIOD;
          state_nxt   = sspwm_pkg::ST_START_DUTY;
        end
      end
      sspwm_pkg::ST_START_DUTY: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = sspwm_pkg::OP_DUTY;
        state_nxt     = sspwm_pkg::ST_DUTY;
      end
      sspwm_pkg::ST_DUTY: begin
        if (sts.div_done) begin
          cmd.div_cap = 1'b1;
          cmd.cap_op  = sspwm_pkg::OP_DUTY;
          state_nxt   = sspwm_pkg::ST_EMIT;
        end
      end
      sspwm_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sspwm_pkg::ST_IDLE;
        end
      end
      sspwm_pkg::ST_COUNT: begin
        if (sts.div_done) begin
          cmd.div_cap = 1'b1;
          cmd.cap_op  = sspwm_pkg::OP_COUNT;
          state_nxt   = sspwm_pkg::ST_START_IVL;
        end
      end
      sspwm_pkg::ST_START_IVL: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = sspwm_pkg::OP_INTERVAL;
        state_nxt     = sspwm_pkg::ST_INTERVAL;
      end
      sspwm_pkg::ST_INTERVAL: begin
        if (sts.div_done) begin
          cmd.commit = 1'b1;
          state_nxt  = sspwm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sspwm_pkg::ST_IDLE;
      end
    endcase
  end

  `SSPWM_ASSERT_SAME(a_start_free, cmd.div_start, !sts.div_busy, "Divide started while busy.")
  `SSPWM_ASSERT_SAME(a_cap_done, cmd.div_cap, sts.div_done, "Quotient taken before done.")
  `SSPWM_ASSERT_SAME(a_emit_free, cmd.emit, sts.out_free, "Result loaded over an unread one.")

endmodule

// ----- sv/sspwm_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo sweep stepper datapath
// Configuration, ramp state, divider operands and the result register.
// ----------------------------------------------------------------------------
`include "servo_sweep_pwm_stepper_macros.svh"

module sspwm_dp #(
  parameter int unsigned DUTY_BITS = sspwm_pkg::DUTY_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [sspwm_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [15:0]                         cfg_wdata,
  input  logic [1:0]                          in_kind,
  input  logic [7:0]                          in_start_angle,
  input  logic [7:0]                          in_target_angle,
  input  logic [15:0]                         in_move_ms,
  input  logic [7:0]                          in_step_degrees,
  input  sspwm_pkg::ctrl_cmd_t                cmd,
  output sspwm_pkg::dp_status_t               sts,
  sspwm_out_if.source                         out_ch
);

  localparam int unsigned DIVW = 16 + DUTY_BITS;
  localparam logic [DIVW-1:0] FULL = DIVW'((64'd1 << DUTY_BITS) - 64'd1);

  logic [15:0]           min_r;
  logic [15:0]           max_r;
  logic [9:0]            freq_r;

  sspwm_pkg::kind_t      kind_r;
  logic [7:0]            start_r;
  logic [7:0]            target_r;
  logic [15:0]           ms_r;
  logic [7:0]            stepin_r;

  logic [7:0]            cur_r;
  logic [7:0]            origin_r;
  logic [7:0]            rtarget_r;
  logic [7:0]            stepsz_r;
  logic                  dir_r;
  logic [7:0]            total_r;
  logic [7:0]            idx_r;
  logic [15:0]           reload_r;
  logic [15:0]           cd_r;
  logic                  active_r;

  logic [7:0]            sel_angle_r;
  logic                  moving_r;
  logic                  fin_r;
  logic [sspwm_pkg::PERIOD_W-1:0] period_r;
  logic [15:0]           pulse_r;
  logic [DUTY_BITS-1:0]  duty_r;
  logic [7:0]            count_r;
  logic [23:0]           pulse_prod_r;

  logic                  out_valid_r;
  logic [15:0]           out_duty_r;
  logic [15:0]           out_pulse_r;
  logic [7:0]            out_angle_r;
  logic                  out_moving_r;
  logic                  out_done_r;

  logic [7:0]            tgt_sat;
  logic [7:0]            start_sat;
  logic [7:0]            mv_start;
  logic [7:0]            step_eff;
  logic [7:0]            distance;
  logic [15:0]           hi;
  logic [15:0]           span;
  logic [9:0]            freq_eff;
  logic [23:0]           pulse_prod;
  logic [44:0]           pulse_mul;
  logic [15:0]           pulse_quo;
  logic [7:0]            idx_inc;
  logic                  step_last;
  logic [15:0]           pos;
  logic [15:0]           up_sum;
  logic [7:0]            up_sat;
  logic [7:0]            down_ang;
  logic [7:0]            step_angle;
  logic [15:0]           ivl;

  logic [DIVW-1:0]       div_dd;
  logic [DIVW-1:0]       div_dv;
  logic [DIVW-1:0]       div_q;
  logic                  div_busy;
  logic                  div_done;

  assign tgt_sat   = (target_r > sspwm_pkg::ANGLE_MAX) ? sspwm_pkg::ANGLE_MAX : target_r;
  assign start_sat = (start_r > sspwm_pkg::ANGLE_MAX) ? sspwm_pkg::ANGLE_MAX : start_r;
  assign mv_start  = (kind_r == sspwm_pkg::KIND_MOVE_FROM) ? start_sat : cur_r;
  assign step_eff  = (stepin_r == 8'd0) ? 8'd1 : stepin_r;
  assign distance  = (mv_start > tgt_sat) ? (mv_start - tgt_sat) : (tgt_sat - mv_start);

  assign hi         = (max_r < min_r) ? min_r : max_r;
  assign span       = hi - min_r;
  assign freq_eff   = (freq_r == 10'd0) ? 10'd1 : freq_r;
  assign pulse_prod = 24'(sel_angle_r) * 24'(span);
  assign pulse_mul  = 45'(pulse_prod_r[23:2]) * 45'(sspwm_pkg::ANGLE_RECIP);
  assign pulse_quo  = 16'(pulse_mul >> sspwm_pkg::ANGLE_RECIP_SH);

  assign idx_inc    = idx_r + 8'd1;
  assign step_last  = idx_inc >= total_r;
  assign pos        = 16'(idx_inc) * 16'(stepsz_r);
  assign up_sum     = 16'(origin_r) + pos;
  assign up_sat     = (up_sum > 16'(sspwm_pkg::ANGLE_MAX)) ? sspwm_pkg::ANGLE_MAX
                                                           : up_sum[7:0];
  assign down_ang   = (pos > 16'(origin_r)) ? 8'd0 : (origin_r - pos[7:0]);
  assign step_angle = step_last ? rtarget_r : (dir_r ? up_sat : down_ang);

  assign ivl = (div_q[15:0] < sspwm_pkg::MIN_INTERVAL) ? sspwm_pkg::MIN_INTERVAL
                                                      : div_q[15:0];

  always_comb begin
    div_dd = '0;
    div_dv = '0;
    case (cmd.div_op)
      sspwm_pkg::OP_PERIOD: begin
        div_dd = DIVW'(sspwm_pkg::US_PER_S);
        div_dv = DIVW'(freq_eff);
      end
      sspwm_pkg::OP_DUTY: begin
        div_dd = {pulse_r, {DUTY_BITS{1'b0}}} - DIVW'(pulse_r);
        div_dv = DIVW'(period_r);
      end
      sspwm_pkg::OP_COUNT: begin
        div_dd = DIVW'(distance);
        div_dv = DIVW'(step_eff);
      end
      sspwm_pkg::OP_INTERVAL: begin
        div_dd = DIVW'(ms_r);
        div_dv = DIVW'(count_r);
      end
      default: begin
        div_dd = '0;
        div_dv = '0;
      end
    endcase
  end

  sspwm_div #(
    .W (DIVW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dd),
    .divisor  (div_dv),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r       <= sspwm_pkg::RST_MIN_PULSE;
      max_r       <= sspwm_pkg::RST_MAX_PULSE;
      freq_r      <= sspwm_pkg::RST_PWM_FREQ;
      cur_r       <= '0;
      origin_r    <= '0;
      rtarget_r   <= '0;
      stepsz_r    <= 8'd1;
      dir_r       <= 1'b0;
      total_r     <= '0;
      idx_r       <= '0;
      reload_r    <= sspwm_pkg::MIN_INTERVAL;
      cd_r        <= '0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          sspwm_pkg::CFG_MIN_PULSE: min_r  <= cfg_wdata;
          sspwm_pkg::CFG_MAX_PULSE: max_r  <= cfg_wdata;
          sspwm_pkg::CFG_PWM_FREQ:  freq_r <= cfg_wdata[9:0];
          default: ;
        endcase
      end
      if (cmd.abort) begin
        active_r <= 1'b0;
      end
      if (cmd.set_step) begin
        stepsz_r <= step_eff;
      end
      if (cmd.tick_count) begin
        cd_r <= cd_r - 16'd1;
      end
      if (cmd.tick_step) begin
        idx_r <= idx_inc;
        if (step_last) begin
          active_r <= 1'b0;
        end else begin
          cd_r <= reload_r;
        end
      end
      if (cmd.commit) begin
        origin_r  <= mv_start;
        rtarget_r <= tgt_sat;
        dir_r     <= tgt_sat > mv_start;
        total_r   <= count_r;
        idx_r     <= '0;
        reload_r  <= ivl;
        cd_r      <= ivl;
        active_r  <= 1'b1;
      end
      if (cmd.emit) begin
        cur_r       <= sel_angle_r;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pulse_prod_r <= pulse_prod;
    if (cmd.load_in) begin
      kind_r   <= sspwm_pkg::kind_t'(in_kind);
      start_r  <= in_start_angle;
      target_r <= in_target_angle;
      ms_r     <= in_move_ms;
      stepin_r <= in_step_degrees;
    end
    if (cmd.set_direct) begin
      sel_angle_r <= tgt_sat;
      moving_r    <= 1'b0;
      fin_r       <= 1'b0;
    end
    if (cmd.tick_step) begin
      sel_angle_r <= step_angle;
      moving_r    <= !step_last;
      fin_r       <= step_last;
    end
    if (cmd.div_cap) begin
      case (cmd.cap_op)
        sspwm_pkg::OP_PERIOD: begin
          period_r <= div_q[sspwm_pkg::PERIOD_W-1:0];
          pulse_r  <= pulse_quo + min_r;
        end
        sspwm_pkg::OP_DUTY:   duty_r   <= (div_q > FULL) ? FULL[DUTY_BITS-1:0]
                                                         : div_q[DUTY_BITS-1:0];
        sspwm_pkg::OP_COUNT:  count_r  <= div_q[7:0];
        default: ;
      endcase
    end
    if (cmd.emit) begin
      out_duty_r   <= 16'(duty_r);
      out_pulse_r  <= pulse_r;
      out_angle_r  <= sel_angle_r;
      out_moving_r <= moving_r;
      out_done_r   <= fin_r;
    end
  end

  assign sts.kind        = kind_r;
  assign sts.ramp_active = active_r;
  assign sts.cd_gt1      = cd_r > 16'd1;
  assign sts.same_angle  = mv_start == tgt_sat;
  assign sts.short_move  = distance <= step_eff;
  assign sts.div_busy    = div_busy;
  assign sts.div_done    = div_done;
  assign sts.out_free    = !out_valid_r || out_ch.ready;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.duty      = out_duty_r;
  assign out_ch.pulse_us  = out_pulse_r;
  assign out_ch.angle_out = out_angle_r;
  assign out_ch.moving    = out_moving_r;
  assign out_ch.move_done = out_done_r;

  `SSPWM_ASSERT_SAME(a_ramp_idx, active_r, idx_r < total_r, "Ramp index past its step count.")
  `SSPWM_ASSERT_SAME(a_reload_min, 1'b1, reload_r >= sspwm_pkg::MIN_INTERVAL, "Interval below floor.")
  `SSPWM_ASSERT_SAME(a_out_angle, out_valid_r, out_angle_r <= sspwm_pkg::ANGLE_MAX, "Angle out of range.")
  `SSPWM_ASSERT_NEXT(a_emit_shows, cmd.emit, out_valid_r && cur_r == out_angle_r, "Result not shown.")

endmodule

// ----- sv/servo_sweep_pwm_stepper.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo sweep PWM stepper
// Servo angle ramp generator that turns each written angle into a pulse
// width and a PWM duty value.
//
// Channel | Direction | Carries
// in_ch   | sink      | kind, start_angle, target_angle, move_ms, step_degrees
// out_ch  | source    | duty, pulse_us, angle_out, moving, move_done
// cfg     | write     | cfg_we, cfg_idx, cfg_wdata (min, max pulse, frequency)
//
// A direct write or a tick that steps the ramp runs two passes of the shared
// radix-2 divider, period then duty; a move that starts a ramp runs two, step
// count then interval. Other requests use no divider. Reset is synchronous and
// loads the default settings, clears the ramp state and the result valid flag.
// A result register lets the next request in while a result waits; a second
// result holds in the controller until the first one is taken.
// ----------------------------------------------------------------------------
module servo_sweep_pwm_stepper #(
  parameter int unsigned DUTY_BITS = sspwm_pkg::DUTY_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  sspwm_in_if.sink                        in_ch,
  sspwm_out_if.source                     out_ch,
  input  logic                            cfg_we,
  input  logic [sspwm_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [15:0]                     cfg_wdata
);

  sspwm_pkg::ctrl_cmd_t  cmd;
  sspwm_pkg::dp_status_t sts;
  logic                  in_ready;

  assign in_ch.ready = in_ready;

  sspwm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sspwm_dp #(
    .DUTY_BITS (DUTY_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_wdata       (cfg_wdata),
    .in_kind         (in_ch.kind),
    .in_start_angle  (in_ch.start_angle),
    .in_target_angle (in_ch.target_angle),
    .in_move_ms      (in_ch.move_ms),
    .in_step_degrees (in_ch.step_degrees),
    .cmd             (cmd),
    .sts             (sts),
    .out_ch          (out_ch)
  );

endmodule

// ----- bench/servo_sweep_pwm_stepper_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo sweep stepper checker
// Watches the request, result and register ports of the servo ramp block.
// It keeps its own copy of the ramp state and pulse settings, works out the
// servo output each accepted request causes, and compares every accepted
// result field by field with the oldest output still due.
// ----------------------------------------------------------------------------
module servo_sweep_pwm_stepper_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  sspwm_in_if                             in_mon,
  sspwm_out_if                            out_mon,
  input  logic                            cfg_we,
  input  logic [sspwm_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [15:0]                     cfg_wdata,
  output int unsigned                     mismatch_count,
  output int unsigned                     results_pending
);
  import sspwm_pkg::*;

  localparam logic [63:0] DUTY_FULL = (64'd1 << DUTY_BITS_DEF) - 64'd1;

  typedef struct packed {
    logic [15:0] duty;
    logic [15:0] pulse_us;
    logic [7:0]  angle;
    logic        moving;
    logic        done;
  } servo_output_t;

  servo_output_t servo_outputs_due[$];

  logic [15:0] min_pulse;
  logic [15:0] max_pulse;
  logic [9:0]  pwm_freq;

  logic [7:0]  current_angle;
  logic [7:0]  ramp_origin;
  logic [7:0]  ramp_target;
  logic [7:0]  step_size;
  logic        ramp_rising;
  logic [7:0]  steps_total;
  logic [7:0]  step_index;
  logic [15:0] interval_reload;
  logic [15:0] interval_countdown;
  logic        ramp_active;

  function automatic logic [7:0] saturate_angle(logic [31:0] a);
    return (a > 32'(ANGLE_MAX)) ? ANGLE_MAX : a[7:0];
  endfunction

  function automatic servo_output_t angle_to_output(logic [7:0] angle, logic mv, logic dn);
    logic [31:0]   lo;
    logic [31:0]   hi;
    logic [31:0]   pulse;
    logic [31:0]   freq;
    logic [63:0]   period;
    logic [63:0]   duty;
    servo_output_t r;
    lo = 32'(min_pulse);
    hi = (max_pulse < min_pulse) ? lo : 32'(max_pulse);
    pulse = 32'(angle) * (hi - lo) / 32'(ANGLE_MAX) + lo;
    freq = (pwm_freq == 10'd0) ? 32'd1 : 32'(pwm_freq);
    period = 64'(32'(US_PER_S) / freq);
    duty = 64'd0;
    if (pulse != 32'd0) begin
      duty = 64'(pulse) * DUTY_FULL / period;
      if (duty > DUTY_FULL) duty = DUTY_FULL;
    end
    r.duty = duty[15:0];
    r.pulse_us = pulse[15:0];
    r.angle = angle;
    r.moving = mv;
    r.done = dn;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic emit_angle(input logic [7:0] angle, input logic mv, input logic dn);
    servo_outputs_due.push_back(angle_to_output(angle, mv, dn));
    current_angle = angle;
  endtask

  task automatic predict_servo_request();
    logic [7:0]  start;
    logic [7:0]  target;
    logic [31:0] step;
    logic [31:0] distance;
    logic [31:0] count;
    logic [31:0] interval;
    logic [31:0] pos;
    logic [7:0]  angle;
    logic        done;
    case (kind_t'(in_mon.kind))
      KIND_WRITE: begin
        ramp_active = 1'b0;
        emit_angle(saturate_angle(32'(in_mon.target_angle)), 1'b0, 1'b0);
      end
      KIND_TICK: begin
        if (ramp_active) begin
          if (interval_countdown > 16'd1) begin
            interval_countdown = interval_countdown - 16'd1;
          end else begin
            step_index = step_index + 8'd1;
            done = (step_index >= steps_total);
            if (done) begin
              angle = ramp_target;
            end else begin
              pos = 32'(step_index) * 32'(step_size);
              if (ramp_rising) pos = 32'(ramp_origin) + pos;
              else pos = (pos > 32'(ramp_origin)) ? 32'd0 : 32'(ramp_origin) - pos;
              angle = saturate_angle(pos);
            end
            if (done) ramp_active = 1'b0;
            else interval_countdown = interval_reload;
            emit_angle(angle, !done, done);
          end
        end
      end
      default: begin
        start = (kind_t'(in_mon.kind) == KIND_MOVE_FROM) ?
                saturate_angle(32'(in_mon.start_angle)) : current_angle;
        target = saturate_angle(32'(in_mon.target_angle));
        ramp_active = 1'b0;
        if (start != target) begin
          step = (in_mon.step_degrees == 8'd0) ? 32'd1 : 32'(in_mon.step_degrees);
          step_size = step[7:0];
          distance = (start > target) ? 32'(start - target) : 32'(target - start);
          if (distance > step) begin
            count = distance / step;
            interval = 32'(in_mon.move_ms) / count;
            if (interval < 32'(MIN_INTERVAL)) interval = 32'(MIN_INTERVAL);
            ramp_origin = start;
            ramp_target = target;
            ramp_rising = (target > start);
            steps_total = count[7:0];
            step_index = 8'd0;
            interval_reload = interval[15:0];
            interval_countdown = interval[15:0];
            ramp_active = 1'b1;
          end
        end
      end
    endcase
  endtask

  task automatic check_servo_output();
    servo_output_t want;
    if (servo_outputs_due.size() == 0) begin
      report_mismatch($sformatf("result with nothing due, angle %0d", out_mon.angle_out));
    end else begin
      want = servo_outputs_due.pop_front();
      if (out_mon.duty !== want.duty)
        report_mismatch($sformatf("duty got %0d want %0d (angle %0d)",
                                  out_mon.duty, want.duty, want.angle));
      if (out_mon.pulse_us !== want.pulse_us)
        report_mismatch($sformatf("pulse_us got %0d want %0d (angle %0d)",
                                  out_mon.pulse_us, want.pulse_us, want.angle));
      if (out_mon.angle_out !== want.angle)
        report_mismatch($sformatf("angle_out got %0d want %0d",
                                  out_mon.angle_out, want.angle));
      if (out_mon.moving !== want.moving)
        report_mismatch($sformatf("moving got %0b want %0b (angle %0d)",
                                  out_mon.moving, want.moving, want.angle));
      if (out_mon.move_done !== want.done)
        report_mismatch($sformatf("move_done got %0b want %0b (angle %0d)",
                                  out_mon.move_done, want.done, want.angle));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      min_pulse = RST_MIN_PULSE;
      max_pulse = RST_MAX_PULSE;
      pwm_freq = RST_PWM_FREQ;
      current_angle = 8'd0;
      ramp_origin = 8'd0;
      ramp_target = 8'd0;
      step_size = 8'd1;
      ramp_rising = 1'b0;
      steps_total = 8'd0;
      step_index = 8'd0;
      interval_reload = MIN_INTERVAL;
      interval_countdown = 16'd0;
      ramp_active = 1'b0;
      servo_outputs_due.delete();
      mismatch_count = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) check_servo_output();
      if (in_mon.valid && in_mon.ready) predict_servo_request();
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_idx))
          CFG_MIN_PULSE: min_pulse = cfg_wdata;
          CFG_MAX_PULSE: max_pulse = cfg_wdata;
          CFG_PWM_FREQ:  pwm_freq = cfg_wdata[9:0];
          default: ;
        endcase
      end
    end
    results_pending = servo_outputs_due.size();
  end

endmodule

// ----- bench/servo_sweep_pwm_stepper_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo sweep stepper testbench
// Drives direct writes, ramp moves and millisecond ticks into the servo ramp
// block under several pulse and frequency settings, with random gaps on the
// request side and random stalls on the result side. The checker beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module servo_sweep_pwm_stepper_tb;
  import sspwm_pkg::*;

  localparam int unsigned RANDOM_REQUESTS = 1650;
  localparam int unsigned SETTING_PHASES  = 6;
  localparam int unsigned DRAIN_CYCLES    = 120;
  localparam int unsigned STALL_LIMIT     = 4000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [15:0]          cfg_wdata = '0;
  int unsigned          mismatch_count;
  int unsigned          results_pending;
  int unsigned          quiet_cycles = 0;
  bit                   steady_flow = 1'b0;

  sspwm_in_if  in_ch ();
  sspwm_out_if out_ch ();

  servo_sweep_pwm_stepper i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  servo_sweep_pwm_stepper_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  function automatic logic [7:0] pick_angle();
    return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(181, 255))
                                       : 8'($urandom_range(0, 180));
  endfunction

  function automatic logic [7:0] pick_step();
    return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(5, 90));
  endfunction

  function automatic logic [15:0] pick_move_ms();
    return ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                       : 16'($urandom_range(0, 400));
  endfunction

  task automatic send_request(input kind_t k, input logic [7:0] start_angle,
                              input logic [7:0] target_angle, input logic [15:0] move_ms,
                              input logic [7:0] step_degrees);
    int unsigned gap;
    gap = steady_flow ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.kind = k;
    in_ch.start_angle = start_angle;
    in_ch.target_angle = target_angle;
    in_ch.move_ms = move_ms;
    in_ch.step_degrees = step_degrees;
    in_ch.valid = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random_tick();
    send_request(KIND_TICK, 8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
  endtask

  task automatic send_noise();
    send_request(kind_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                 16'($urandom), 8'($urandom));
  endtask

  task automatic settle();
    in_ch.valid = 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input cfg_idx_t idx, input logic [15:0] value);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic program_setting(input int unsigned phase);
    logic [15:0] lo;
    case (phase)
      1: begin
        write_register(CFG_MIN_PULSE, 16'd0);
        write_register(CFG_MAX_PULSE, 16'hFFFF);
        write_register(CFG_PWM_FREQ, 16'd1000);
      end
      2: begin
        write_register(CFG_MIN_PULSE, 16'd3000);
        write_register(CFG_MAX_PULSE, 16'd1000);
        write_register(CFG_PWM_FREQ, 16'd0);
      end
      3: begin
        write_register(CFG_MIN_PULSE, 16'd0);
        write_register(CFG_MAX_PULSE, 16'd0);
        write_register(CFG_PWM_FREQ, 16'd1);
      end
      default: begin
        lo = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3000));
        write_register(CFG_MIN_PULSE, lo);
        write_register(CFG_MAX_PULSE, ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                                      16'(32'(lo) + $urandom_range(0, 4000)));
        write_register(CFG_PWM_FREQ, 16'($urandom_range(1, 1000)));
      end
    endcase
  endtask

  task automatic run_directed();
    send_request(KIND_WRITE, 8'h00, 8'd0, 16'h0000, 8'h00);
    send_request(KIND_WRITE, 8'hFF, 8'd255, 16'hFFFF, 8'hFF);
    send_request(KIND_WRITE, 8'h00, 8'd90, 16'h0000, 8'h00);
    send_request(KIND_TICK, 8'h00, 8'h00, 16'h0000, 8'h00);
    send_request(KIND_MOVE_LAST, 8'd0, 8'd100, 16'd1000, 8'd20);
    send_request(KIND_MOVE_FROM, 8'd50, 8'd50, 16'd1000, 8'd1);
    send_request(KIND_MOVE_FROM, 8'd255, 8'd0, 16'hFFFF, 8'd0);
    send_request(KIND_TICK, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
    send_request(KIND_WRITE, 8'd0, 8'd45, 16'd0, 8'd0);
    send_request(KIND_TICK, 8'h00, 8'h00, 16'h0000, 8'h00);
    send_request(KIND_MOVE_LAST, 8'd0, 8'd0, 16'd5, 8'd40);
    repeat (10) send_random_tick();
  endtask

  task automatic run_random(input int unsigned quota);
    int unsigned sent;
    int unsigned roll;
    int unsigned ticks;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(0, 15) == 0) steady_flow = !steady_flow;
      roll = $urandom_range(0, 9);
      if (roll < 6) begin
        send_request(($urandom_range(0, 1) == 0) ? KIND_MOVE_LAST : KIND_MOVE_FROM,
                     pick_angle(), pick_angle(), pick_move_ms(), pick_step());
        ticks = $urandom_range(5, 80);
        if (sent + 1 + ticks > quota) ticks = quota - sent - 1;
        repeat (ticks) begin
          if ($urandom_range(0, 39) == 0) send_noise();
          else send_random_tick();
        end
        sent = sent + 1 + ticks;
      end else if (roll < 8) begin
        send_request(KIND_WRITE, 8'($urandom), pick_angle(), 16'($urandom), 8'($urandom));
        sent++;
      end else begin
        send_noise();
        sent++;
      end
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_MOVE_LAST;
    in_ch.start_angle = 8'd0;
    in_ch.target_angle = 8'd0;
    in_ch.move_ms = 16'd0;
    in_ch.step_degrees = 8'd0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    run_directed();
    for (int unsigned phase = 0; phase < SETTING_PHASES; phase++) begin
      if (phase != 0) begin
        settle();
        program_setting(phase);
      end
      steady_flow = 1'b0;
      run_random(RANDOM_REQUESTS / SETTING_PHASES);
    end
    settle();
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/sspwm_pkg.sv
sv/sspwm_ifs.sv
sv/sspwm_div.sv
sv/sspwm_ctrl.sv
sv/sspwm_dp.sv
sv/servo_sweep_pwm_stepper.sv
bench/servo_sweep_pwm_stepper_checker.sv
bench/servo_sweep_pwm_stepper_tb.sv
